@@ rtl/assert_macros.svh @@
// Assertion helpers used by the port checker in rtl/mlbt_checker.sv.
// Both sample on clk and are switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MLBT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MLBT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mlbt_pkg.sv @@
// Maglev backend table: shared constants, payload types, controller codes.
// No dependencies; all other files but mlbt_ram and assert_macros.svh import it.
package mlbt_pkg;

  localparam int TABLE_SIZE   = 1021;
  localparam int MAX_BACKENDS = 64;
  localparam int ADDR_W       = 128;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 7;
  localparam int SLOT_W       = 10;
  localparam int TBL_W        = $clog2(TABLE_SIZE);
  localparam int CUR_W        = $clog2(TABLE_SIZE + 1);
  localparam int BE_AW        = $clog2(MAX_BACKENDS);
  localparam int TE_W         = IDX_W + 1;
  localparam int PB_W         = 2 * TBL_W + CUR_W;

  localparam logic [31:0] MM_MUL   = 32'h5bd1e995;
  localparam logic [31:0] MM_SEED  = 32'd16;
  localparam logic [31:0] DJB_INIT = 32'd5381;
  localparam int MM_R  = 24;
  localparam int MM_F1 = 13;
  localparam int MM_F2 = 15;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_READ = 2'd2,
    KIND_NOP  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [63:0]        addr_high;
    logic [63:0]        addr_low;
    logic [SLOT_W-1:0]  slot;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [IDX_W-1:0]   backend_index;
    logic [63:0]        backend_addr_high;
    logic [63:0]        backend_addr_low;
    logic [CNT_W-1:0]   count;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLR, OP_ACCEPT, OP_ADD_INIT, OP_ADD_RD, OP_ADD_SHIFT, OP_ADD_PUT,
    OP_DEL_INIT, OP_DEL_RD, OP_DEL_CHK, OP_DEL_END, OP_RD_TBL, OP_RD_BE,
    OP_RESP, OP_RESP_FULL, OP_RB_INIT, OP_H_RD, OP_H_START, OP_H_STORE,
    OP_T_CLR, OP_CL_INIT, OP_CL_RDP, OP_CL_LDP, OP_CL_PROBE, OP_CL_CLAIM,
    OP_CL_NEXT, OP_FILL_INIT, OP_FILL_RD, OP_FILL_WR
  } op_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_ADD_RD, S_ADD_CMP, S_ADD_PUT,
    S_DEL_RD, S_DEL_CHK, S_DEL_END, S_DEL_TEST, S_RD_T, S_RD_B, S_RD_OUT,
    S_RB_INIT, S_H_RD, S_H_START, S_H_WAIT, S_T_CLR, S_CL_INIT, S_CL_RDP,
    S_CL_LDP, S_CL_PROBE, S_CL_CHK, S_CL_NEXT, S_FILL_INIT, S_FILL_RD,
    S_FILL_WR, S_RESP
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  cnt_zero;
    logic  slot_oob;
    logic  idx_zero;
    logic  idx_last;
    logic  greater;
    logic  equal;
    logic  hash_done;
    logic  sc_last;
    logic  taken;
    logic  progress;
    logic  filled_full;
    logic  cur_end;
  } st_t;

endpackage

@@ rtl/mlbt_ram.sv @@
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
module mlbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ rtl/mlbt_hash.sv @@
// Iterative hash unit: MurmurHash2 and djb of one address, reduced to offset and skip.
// Depends on mlbt_pkg. The Murmur multiplies share one 32x32 multiplier.
module mlbt_hash (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mlbt_pkg::ADDR_W-1:0] addr,
  output logic                       done,
  output logic [mlbt_pkg::TBL_W-1:0]  offset,
  output logic [mlbt_pkg::TBL_W-1:0]  skip
);
  import mlbt_pkg::*;

  localparam logic [5:0]  DJB_STEPS = 6'd16;
  localparam logic [5:0]  LAST_STEP = 6'd20;
  // 2^TBL_W folded back in as its residue
  localparam logic [31:0] OFF_FOLD  = 32'((1 << TBL_W) - TABLE_SIZE);
  localparam logic [31:0] SKP_FOLD  = 32'((1 << TBL_W) - (TABLE_SIZE - 1));

  logic              run;
  logic [5:0]        cnt;
  logic [ADDR_W-1:0] ms, ds;
  logic [31:0]       mk, mh, dh;
  logic [2:0]        mg;
  logic [1:0]        msub;
  logic [TBL_W-1:0]  r_off, r_skp;
  logic [31:0]       mul_in, prod, kin, dh_next;

  // group bytes are little endian, address byte 4g lowest
  assign kin = {ms[103:96], ms[111:104], ms[119:112], ms[127:120]};
  assign dh_next = (dh << 5) + dh + {24'd0, ds[ADDR_W-1 -: 8]};

  always_comb begin
    if (mg < 3'd4) begin
      case (msub)
        2'd0:    mul_in = kin;
        2'd1:    mul_in = mk ^ (mk >> MM_R);
        default: mul_in = mh;
      endcase
    end else if (mg == 3'd4 && msub == 2'd0) begin
      mul_in = mh ^ (mh >> MM_F1);
    end else begin
      mul_in = mh;
    end
  end

  assign prod = 32'(mul_in * MM_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        cnt   <= '0;
        ms    <= addr;
        ds    <= addr;
        mh    <= MM_SEED;
        dh    <= DJB_INIT;
        mg    <= '0;
        msub  <= '0;
        r_off <= '0;
        r_skp <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt < DJB_STEPS) begin
          dh <= (cnt == DJB_STEPS - 6'd1) ? {1'b0, dh_next[30:0]} : dh_next;
          ds <= ds << 8;
          if (mg < 3'd4) begin
            case (msub)
              2'd0: begin
                mk   <= prod;
                msub <= 2'd1;
              end
              2'd1: begin
                mk   <= prod;
                msub <= 2'd2;
              end
              default: begin
                mh   <= prod ^ mk;
                msub <= 2'd0;
                mg   <= mg + 3'd1;
                ms   <= ms << 32;
              end
            endcase
          end else if (mg == 3'd4) begin
            if (msub == 2'd0) begin
              mh   <= prod;
              msub <= 2'd1;
            end else begin
              mh <= mh ^ (mh >> MM_F2);
              mg <= 3'd5;
            end
          end
        end else if (cnt < LAST_STEP) begin
          // four folds bring both hashes below 2^(TBL_W+1)
          mh <= 32'((mh >> TBL_W) * OFF_FOLD) + 32'(mh[TBL_W-1:0]);
          dh <= 32'((dh >> TBL_W) * SKP_FOLD) + 32'(dh[TBL_W-1:0]);
        end else begin
          r_off <= (mh >= 32'(TABLE_SIZE)) ? TBL_W'(mh - 32'(TABLE_SIZE)) : mh[TBL_W-1:0];
          r_skp <= (dh >= 32'(TABLE_SIZE - 1)) ?
                   TBL_W'(dh - 32'(TABLE_SIZE - 1)) : dh[TBL_W-1:0];
          run   <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

  assign offset = r_off;
  assign skip   = r_skp + 1'b1;

endmodule

@@ rtl/mlbt_ctrl.sv @@
// Controller state machine: sequences reset clear, list edits, rebuild and reads.
// Depends on mlbt_pkg; drives the datapath by micro-op commands.
module mlbt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mlbt_pkg::st_t  st,
  output mlbt_pkg::cmd_t cmd,
  output logic           busy
);
  import mlbt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLR;
        if (st.sc_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (st.kind)
          KIND_ADD: begin
            if (st.full) begin
              cmd.op     = OP_RESP_FULL;
              state_next = S_IDLE;
            end else begin
              cmd.op     = OP_ADD_INIT;
              state_next = st.cnt_zero ? S_ADD_PUT : S_ADD_RD;
            end
          end
          KIND_DEL: begin
            cmd.op     = OP_DEL_INIT;
            state_next = st.cnt_zero ? S_DEL_END : S_DEL_RD;
          end
          KIND_READ: begin
            if (st.slot_oob) begin
              cmd.op     = OP_RESP;
              state_next = S_IDLE;
            end else begin
              state_next = S_RD_T;
            end
          end
          default: begin
            cmd.op     = OP_RESP;
            state_next = S_IDLE;
          end
        endcase
      end
      // insertion walks down from the top, shifting larger entries up
      S_ADD_RD: begin
        cmd.op     = OP_ADD_RD;
        state_next = S_ADD_CMP;
      end
      S_ADD_CMP: begin
        if (st.greater) begin
          cmd.op     = OP_ADD_SHIFT;
          state_next = st.idx_zero ? S_ADD_PUT : S_ADD_RD;
        end else begin
          cmd.op     = OP_ADD_PUT;
          state_next = S_RB_INIT;
        end
      end
      S_ADD_PUT: begin
        cmd.op     = OP_ADD_PUT;
        state_next = S_RB_INIT;
      end
      S_DEL_RD: begin
        cmd.op     = OP_DEL_RD;
        state_next = S_DEL_CHK;
      end
      S_DEL_CHK: begin
        cmd.op     = OP_DEL_CHK;
        state_next = st.idx_last ? S_DEL_END : S_DEL_RD;
      end
      S_DEL_END: begin
        cmd.op     = OP_DEL_END;
        state_next = S_DEL_TEST;
      end
      S_DEL_TEST: begin
        if (st.cnt_zero) begin
          cmd.op     = OP_RESP;
          state_next = S_IDLE;
        end else begin
          state_next = S_RB_INIT;
        end
      end
      S_RD_T: begin
        cmd.op     = OP_RD_TBL;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        cmd.op     = OP_RD_BE;
        state_next = S_RD_OUT;
      end
      S_RD_OUT: begin
        cmd.op     = OP_RESP;
        state_next = S_IDLE;
      end
      S_RB_INIT: begin
        cmd.op     = OP_RB_INIT;
        state_next = S_H_RD;
      end
      S_H_RD: begin
        cmd.op     = OP_H_RD;
        state_next = S_H_START;
      end
      S_H_START: begin
        cmd.op     = OP_H_START;
        state_next = S_H_WAIT;
      end
      S_H_WAIT: begin
        if (st.hash_done) begin
          cmd.op     = OP_H_STORE;
          state_next = st.idx_last ? S_T_CLR : S_H_RD;
        end
      end
      S_T_CLR: begin
        cmd.op = OP_T_CLR;
        if (st.sc_last) state_next = S_CL_INIT;
      end
      S_CL_INIT: begin
        cmd.op     = OP_CL_INIT;
        state_next = S_CL_RDP;
      end
      S_CL_RDP: begin
        cmd.op     = OP_CL_RDP;
        state_next = S_CL_LDP;
      end
      S_CL_LDP: begin
        cmd.op     = OP_CL_LDP;
        state_next = S_CL_PROBE;
      end
      S_CL_PROBE: begin
        if (st.cur_end) begin
          state_next = S_CL_NEXT;
        end else begin
          cmd.op     = OP_CL_PROBE;
          state_next = S_CL_CHK;
        end
      end
      S_CL_CHK: begin
        if (st.taken) begin
          state_next = S_CL_PROBE;
        end else begin
          cmd.op     = OP_CL_CLAIM;
          state_next = S_CL_NEXT;
        end
      end
      S_CL_NEXT: begin
        cmd.op = OP_CL_NEXT;
        // table full, or a whole round without a claim
        if (st.filled_full || (st.idx_last && !st.progress)) state_next = S_FILL_INIT;
        else state_next = S_CL_RDP;
      end
      S_FILL_INIT: begin
        cmd.op     = OP_FILL_INIT;
        state_next = S_FILL_RD;
      end
      S_FILL_RD: begin
        cmd.op     = OP_FILL_RD;
        state_next = S_FILL_WR;
      end
      S_FILL_WR: begin
        cmd.op     = OP_FILL_WR;
        state_next = st.sc_last ? S_RESP : S_FILL_RD;
      end
      S_RESP: begin
        cmd.op     = OP_RESP;
        state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

@@ rtl/mlbt_datapath.sv @@
// Datapath: backend list, lookup table and per-backend rebuild RAMs, counters, result.
// Depends on mlbt_pkg, mlbt_ram and mlbt_hash; executes one micro-op per cycle.
module mlbt_datapath (
  input  logic           clk,
  input  logic           rst,
  input  mlbt_pkg::cmd_t cmd,
  input  mlbt_pkg::req_t request,
  output mlbt_pkg::st_t  st,
  output logic           done,
  output mlbt_pkg::rsp_t result
);
  import mlbt_pkg::*;

  req_t              req;
  logic [CNT_W-1:0]  count, idx, cnt_m1;
  logic [TBL_W-1:0]  sc, sc_adv, pos, skp, p, pos_adv;
  logic [TBL_W:0]    pos_sum;
  logic [IDX_W-1:0]  fm, b;
  logic              found, progress;
  logic [CUR_W-1:0]  filled, cur;
  logic [ADDR_W-1:0] new_addr;

  logic              be_we, be_re;
  logic [BE_AW-1:0]  be_waddr, be_raddr;
  logic [ADDR_W-1:0] be_wdata, be_rdata;
  logic              tb_we, tb_re;
  logic [TBL_W-1:0]  tb_waddr, tb_raddr;
  logic [TE_W-1:0]   tb_wdata, tb_rdata;
  logic              pb_we, pb_re;
  logic [BE_AW-1:0]  pb_waddr, pb_raddr;
  logic [PB_W-1:0]   pb_wdata, pb_rdata;

  logic              h_start, h_done;
  logic [TBL_W-1:0]  h_off, h_skip;

  assign new_addr = {req.addr_high, req.addr_low};
  assign cnt_m1   = count - 1'b1;
  assign sc_adv   = st.sc_last ? '0 : sc + 1'b1;
  assign pos_sum  = {1'b0, pos} + {1'b0, skp};
  assign pos_adv  = (pos_sum >= (TBL_W+1)'(TABLE_SIZE)) ?
                    TBL_W'(pos_sum - (TBL_W+1)'(TABLE_SIZE)) : pos_sum[TBL_W-1:0];

  always_comb begin
    st.kind        = req.kind;
    st.full        = (count >= CNT_W'(MAX_BACKENDS));
    st.cnt_zero    = (count == '0);
    st.slot_oob    = (32'(req.slot) >= TABLE_SIZE);
    st.idx_zero    = (idx == '0);
    st.idx_last    = (idx == cnt_m1);
    st.greater     = (be_rdata > new_addr);
    st.equal       = (be_rdata == new_addr);
    st.hash_done   = h_done;
    st.sc_last     = (sc == TBL_W'(TABLE_SIZE - 1));
    st.taken       = tb_rdata[TE_W-1];
    st.progress    = progress;
    st.filled_full = (filled == CUR_W'(TABLE_SIZE));
    st.cur_end     = (cur >= CUR_W'(TABLE_SIZE));
  end

  // RAM port steering
  always_comb begin
    be_we = 1'b0;  be_re = 1'b0;
    be_waddr = idx[BE_AW-1:0];  be_raddr = idx[BE_AW-1:0];  be_wdata = '0;
    tb_we = 1'b0;  tb_re = 1'b0;
    tb_waddr = sc;  tb_raddr = sc;  tb_wdata = '0;
    pb_we = 1'b0;  pb_re = 1'b0;
    pb_waddr = idx[BE_AW-1:0];  pb_raddr = idx[BE_AW-1:0];  pb_wdata = '0;
    h_start = 1'b0;
    unique case (cmd.op)
      OP_CLR: begin
        tb_we    = 1'b1;
        be_we    = (32'(sc) < MAX_BACKENDS);
        be_waddr = sc[BE_AW-1:0];
      end
      OP_ADD_RD, OP_DEL_RD, OP_H_RD: be_re = 1'b1;
      OP_ADD_SHIFT: begin
        be_we    = 1'b1;
        be_waddr = BE_AW'(idx + 1'b1);
        be_wdata = be_rdata;
      end
      OP_ADD_PUT: begin
        be_we    = 1'b1;
        be_waddr = BE_AW'(idx + 1'b1);
        be_wdata = new_addr;
      end
      OP_DEL_CHK: begin
        be_we    = found;
        be_waddr = BE_AW'(idx - 1'b1);
        be_wdata = be_rdata;
      end
      OP_DEL_END: begin
        be_we    = found;
        be_waddr = cnt_m1[BE_AW-1:0];
      end
      OP_RD_TBL: begin
        tb_re    = 1'b1;
        tb_raddr = TBL_W'(req.slot);
      end
      OP_RD_BE: begin
        be_re    = 1'b1;
        be_raddr = BE_AW'(tb_rdata[IDX_W-1:0]);
      end
      OP_H_START: h_start = 1'b1;
      OP_H_STORE: begin
        pb_we    = 1'b1;
        pb_wdata = {h_off, h_skip, {CUR_W{1'b0}}};
      end
      OP_T_CLR: tb_we = 1'b1;
      OP_CL_RDP: pb_re = 1'b1;
      OP_CL_PROBE: begin
        tb_re    = 1'b1;
        tb_raddr = pos;
      end
      OP_CL_CLAIM: begin
        tb_we    = 1'b1;
        tb_waddr = p;
        tb_wdata = {1'b1, idx[IDX_W-1:0]};
      end
      OP_CL_NEXT: begin
        pb_we    = 1'b1;
        pb_wdata = {pos, skp, cur};
      end
      OP_FILL_RD: tb_re = 1'b1;
      OP_FILL_WR: begin
        tb_we    = !tb_rdata[TE_W-1];
        tb_wdata = {1'b0, fm};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sc    <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (cmd.op)
        OP_CLR, OP_T_CLR: sc <= sc_adv;
        OP_ACCEPT:   req <= request;
        OP_ADD_INIT: idx <= cnt_m1;
        OP_ADD_SHIFT: idx <= idx - 1'b1;
        OP_ADD_PUT:  count <= count + 1'b1;
        OP_DEL_INIT: begin
          idx   <= '0;
          found <= 1'b0;
        end
        OP_DEL_CHK: begin
          if (!found && st.equal) found <= 1'b1;
          idx <= idx + 1'b1;
        end
        OP_DEL_END: if (found) count <= cnt_m1;
        OP_RD_BE:   b <= tb_rdata[IDX_W-1:0];
        OP_RESP: begin
          done                     <= 1'b1;
          result.status            <= 1'b0;
          result.count             <= count;
          if (req.kind == KIND_READ && !st.slot_oob) begin
            result.backend_index     <= b;
            result.backend_addr_high <= be_rdata[ADDR_W-1 -: 64];
            result.backend_addr_low  <= be_rdata[63:0];
          end else begin
            result.backend_index     <= '0;
            result.backend_addr_high <= '0;
            result.backend_addr_low  <= '0;
          end
        end
        OP_RESP_FULL: begin
          done                     <= 1'b1;
          result.status            <= 1'b1;
          result.count             <= count;
          result.backend_index     <= '0;
          result.backend_addr_high <= '0;
          result.backend_addr_low  <= '0;
        end
        OP_RB_INIT: idx <= '0;
        OP_H_STORE: idx <= idx + 1'b1;
        OP_CL_INIT: begin
          idx      <= '0;
          progress <= 1'b0;
          filled   <= '0;
        end
        OP_CL_LDP: {pos, skp, cur} <= pb_rdata;
        OP_CL_PROBE: begin
          p   <= pos;
          pos <= pos_adv;
          cur <= cur + 1'b1;
        end
        OP_CL_CLAIM: begin
          filled   <= filled + 1'b1;
          progress <= 1'b1;
        end
        OP_CL_NEXT: begin
          if (st.idx_last) begin
            idx      <= '0;
            progress <= 1'b0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        OP_FILL_INIT: begin
          sc <= '0;
          fm <= '0;
        end
        OP_FILL_WR: begin
          sc <= sc_adv;
          // running slot mod count
          fm <= ({1'b0, fm} == cnt_m1) ? '0 : fm + 1'b1;
        end
        default: ;
      endcase
    end
  end

  mlbt_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_BACKENDS)) u_be_ram (
    .clk(clk), .we(be_we), .waddr(be_waddr), .wdata(be_wdata),
    .re(be_re), .raddr(be_raddr), .rdata(be_rdata)
  );

  mlbt_ram #(.WIDTH(TE_W), .DEPTH(TABLE_SIZE)) u_tb_ram (
    .clk(clk), .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata),
    .re(tb_re), .raddr(tb_raddr), .rdata(tb_rdata)
  );

  mlbt_ram #(.WIDTH(PB_W), .DEPTH(MAX_BACKENDS)) u_pb_ram (
    .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
    .re(pb_re), .raddr(pb_raddr), .rdata(pb_rdata)
  );

  mlbt_hash u_hash (
    .clk(clk), .rst(rst), .start(h_start), .addr(be_rdata),
    .done(h_done), .offset(h_off), .skip(h_skip)
  );

endmodule

@@ rtl/maglev_backend_table_unit.sv @@
// Maglev backend table top level: controller plus datapath.
// Depends on mlbt_pkg, mlbt_ctrl, mlbt_datapath.
//
// Usage: a request is taken when start is high and busy is low. kind selects
// add, delete, slot read or no-op. Exactly one result per request appears on
// result for one cycle with done high; it cannot be held off.
// Slot read: table RAM read, then backend RAM read. Add and delete edit the
// sorted list one entry at a time, then rebuild: each backend is hashed in the
// iterative hash unit, the table is cleared, backends claim slots in turn by
// probing past taken slots, and a leftover fill covers the unclaimed slots.
// Requests are handled one at a time; busy stays high until the result.
// Reset: a clearing pass zeroes the table and backend RAMs; busy is
// high during it. Delete of the last backend keeps the old table contents.
module maglev_backend_table_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mlbt_pkg::req_t request,
  output logic           busy,
  output logic           done,
  output mlbt_pkg::rsp_t result
);
  import mlbt_pkg::*;

  cmd_t cmd;
  st_t  st;

  mlbt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .st(st), .cmd(cmd), .busy(busy)
  );

  mlbt_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .request(request),
    .st(st), .done(done), .result(result)
  );

endmodule

@@ rtl/mlbt_checker.sv @@
// Port-level checker for the Maglev backend table, bound to the top level.
// Depends on mlbt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mlbt_port_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input mlbt_pkg::rsp_t result
);
  import mlbt_pkg::*;

  `MLBT_ASSERT_IMP(a_done_after_busy, done, $past(busy), "result without request in flight")
  `MLBT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `MLBT_ASSERT_IMP(a_count_range, done, result.count <= 7'(MAX_BACKENDS), "count out of range")
  `MLBT_ASSERT_IMP(a_full_result, done && result.status, result.count == 7'(MAX_BACKENDS) && result.backend_index == '0, "full status with bad fields")

endmodule

bind maglev_backend_table_unit mlbt_port_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);

@@ verif/mlbt_checker.sv @@
// Checker for the Maglev backend table: watches the request and result channels,
// predicts each result from its own copy of the backend list and lookup table.
// Depends on mlbt_pkg for the payload structs and kind codes.
module mlbt_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  logic            done,
  input  mlbt_pkg::req_t  request,
  input  mlbt_pkg::rsp_t  result,
  output int              errors,
  output int              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import mlbt_pkg::*;

  logic [63:0] list_hi [MAX_BACKENDS];
  logic [63:0] list_lo [MAX_BACKENDS];
  int unsigned list_n;
  logic [IDX_W-1:0] slot_owner [TABLE_SIZE];
  rsp_t rsp_queue [$];

  assign outstanding = rsp_queue.size();

  function automatic logic [31:0] murmur_addr(logic [127:0] a);
    logic [31:0] h, k, w;
    h = MM_SEED;
    for (int g = 0; g < 4; g++) begin
      w = a[127-32*g -: 32];
      // groups are read little-endian starting at address byte 0
      k = {w[7:0], w[15:8], w[23:16], w[31:24]};
      k = k * MM_MUL;
      k = k ^ (k >> MM_R);
      k = k * MM_MUL;
      h = h * MM_MUL;
      h = h ^ k;
    end
    h = h ^ (h >> MM_F1);
    h = h * MM_MUL;
    h = h ^ (h >> MM_F2);
    return h;
  endfunction

  function automatic logic [31:0] djb_addr(logic [127:0] a);
    logic [31:0] h;
    h = DJB_INIT;
    for (int i = 0; i < 16; i++) h = (h << 5) + h + {24'd0, a[127-8*i -: 8]};
    return h & 32'h7fffffff;
  endfunction

  function automatic void rebuild_table();
    int unsigned offs [MAX_BACKENDS];
    int unsigned skp [MAX_BACKENDS];
    int unsigned cur [MAX_BACKENDS];
    bit taken [TABLE_SIZE];
    int unsigned filled, p;
    bit progress, full;
    if (list_n == 0) return;
    for (int i = 0; i < list_n; i++) begin
      offs[i] = murmur_addr({list_hi[i], list_lo[i]}) % TABLE_SIZE;
      skp[i] = djb_addr({list_hi[i], list_lo[i]}) % (TABLE_SIZE - 1) + 1;
      cur[i] = 0;
    end
    for (int s = 0; s < TABLE_SIZE; s++) taken[s] = 0;
    filled = 0;
    full = 0;
    do begin
      progress = 0;
      for (int i = 0; i < list_n && !full; i++) begin
        while (cur[i] < TABLE_SIZE) begin
          p = (longint'(offs[i]) + longint'(cur[i]) * longint'(skp[i])) % TABLE_SIZE;
          cur[i]++;
          if (!taken[p]) begin
            taken[p] = 1;
            slot_owner[p] = i[IDX_W-1:0];
            progress = 1;
            filled++;
            if (filled == TABLE_SIZE) full = 1;
            break;
          end
        end
      end
    end while (!full && progress);
    for (int s = 0; s < TABLE_SIZE; s++)
      if (!taken[s]) slot_owner[s] = IDX_W'(s % list_n);
  endfunction

  function automatic rsp_t predict_rsp(req_t r);
    rsp_t o;
    int unsigned pos;
    o = '0;
    case (r.kind)
      KIND_ADD: begin
        if (list_n >= MAX_BACKENDS) begin
          o.status = 1'b1;
        end else begin
          pos = list_n;
          for (int i = 0; i < list_n; i++)
            if ({list_hi[i], list_lo[i]} > {r.addr_high, r.addr_low}) begin
              pos = i;
              break;
            end
          for (int i = list_n; i > pos; i--) begin
            list_hi[i] = list_hi[i-1];
            list_lo[i] = list_lo[i-1];
          end
          list_hi[pos] = r.addr_high;
          list_lo[pos] = r.addr_low;
          list_n++;
          rebuild_table();
        end
      end
      KIND_DEL: begin
        for (int i = 0; i < list_n; i++)
          if (list_hi[i] == r.addr_high && list_lo[i] == r.addr_low) begin
            for (int j = i; j + 1 < list_n; j++) begin
              list_hi[j] = list_hi[j+1];
              list_lo[j] = list_lo[j+1];
            end
            list_hi[list_n-1] = '0;
            list_lo[list_n-1] = '0;
            list_n--;
            break;
          end
        // the last backend leaving keeps the old table
        if (list_n != 0) rebuild_table();
      end
      KIND_READ: begin
        if (r.slot < TABLE_SIZE) begin
          o.backend_index = slot_owner[r.slot];
          o.backend_addr_high = list_hi[slot_owner[r.slot]];
          o.backend_addr_low = list_lo[slot_owner[r.slot]];
        end
      end
      default: ;
    endcase
    o.count = CNT_W'(list_n);
    return o;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  rsp_t want;

  initial errors = 0;

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_BACKENDS; i++) begin
        list_hi[i] = '0;
        list_lo[i] = '0;
      end
      for (int s = 0; s < TABLE_SIZE; s++) slot_owner[s] = '0;
      list_n = 0;
      rsp_queue.delete();
    end else begin
      if (done) begin
        if (rsp_queue.size() == 0) begin
          report("unexpected result", 64'(result.count), 64'd0);
        end else begin
          want = rsp_queue.pop_front();
          if (result.status !== want.status)
            report("status", 64'(result.status), 64'(want.status));
          if (result.backend_index !== want.backend_index)
            report("backend_index", 64'(result.backend_index), 64'(want.backend_index));
          if (result.backend_addr_high !== want.backend_addr_high)
            report("backend_addr_high", result.backend_addr_high, want.backend_addr_high);
          if (result.backend_addr_low !== want.backend_addr_low)
            report("backend_addr_low", result.backend_addr_low, want.backend_addr_low);
          if (result.count !== want.count)
            report("count", 64'(result.count), 64'(want.count));
        end
      end
      if (start && !busy) rsp_queue.push_back(predict_rsp(request));
    end
  end

endmodule

@@ verif/maglev_backend_table_unit_tb.sv @@
// Testbench top for maglev_backend_table_unit: directed and random requests,
// random idle gaps, verdict from the failure count of mlbt_checker.
// Depends on mlbt_pkg, mlbt_checker and the block itself.
module maglev_backend_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mlbt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy, done;
  rsp_t result;
  int errors, outstanding;

  logic [127:0] live [$];
  bit quiet;

  always #1 clk = ~clk;

  maglev_backend_table_unit u_top (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .done(done), .result(result)
  );

  mlbt_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .request(request), .result(result), .errors(errors), .outstanding(outstanding)
  );

  task automatic send(kind_t k, logic [127:0] a, logic [SLOT_W-1:0] s);
    int idx;
    if (!quiet && $urandom_range(99) < 21) repeat ($urandom_range(1, 4)) @(negedge clk);
    request = '{kind: k, addr_high: a[127:64], addr_low: a[63:0], slot: s};
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
    // mirror the list so deletes can aim at live backends
    if (k == KIND_ADD && live.size() < MAX_BACKENDS) live.push_back(a);
    if (k == KIND_DEL) begin
      idx = -1;
      foreach (live[i]) if (live[i] == a && idx < 0) idx = i;
      if (idx >= 0) live.delete(idx);
    end
  endtask

  function automatic logic [127:0] rand_addr();
    logic [127:0] a;
    a = {$urandom, $urandom, $urandom, $urandom};
    // some share the upper half so ordering falls to the lower half
    if ($urandom_range(3) == 0) a[127:64] = 64'h2001_0db8_0000_0000;
    return a;
  endfunction

  task automatic read_some(int n);
    repeat (n) send(KIND_READ, rand_addr(), SLOT_W'($urandom_range(1023)));
  endtask

  initial begin
    quiet = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty table, extremes, duplicates, miss, last delete
    send(KIND_READ, '0, 10'd0);
    send(KIND_READ, '1, 10'd1020);
    send(KIND_READ, '0, 10'd1021);
    send(KIND_NOP, '1, 10'd1023);
    send(KIND_DEL, '0, 10'd0);
    send(KIND_ADD, '0, 10'd0);
    send(KIND_ADD, '1, 10'd0);
    send(KIND_ADD, '1, 10'd1023);
    send(KIND_READ, '0, 10'd0);
    send(KIND_READ, '0, 10'd1020);
    send(KIND_READ, '0, 10'd1023);
    send(KIND_DEL, 128'h1, 10'd0);
    send(KIND_DEL, '1, 10'd0);
    send(KIND_DEL, '1, 10'd0);
    send(KIND_READ, '0, 10'd512);
    send(KIND_DEL, '0, 10'd0);
    send(KIND_READ, '0, 10'd1);
    send(KIND_READ, '0, 10'd777);

    // fill the list to the limit, then adds must report full
    while (live.size() < MAX_BACKENDS) begin
      quiet = (live.size() >= 20 && live.size() < 40);
      if ($urandom_range(9) == 0) read_some(1);
      else send(KIND_ADD, (live.size() > 0 && $urandom_range(7) == 0) ?
                live[$urandom_range(live.size() - 1)] : rand_addr(), '0);
    end
    quiet = 0;
    read_some(4);
    send(KIND_ADD, rand_addr(), '0);
    send(KIND_ADD, '1, '0);
    read_some(4);

    // mixed tail: deletes mostly of live backends, some misses, adds, no-ops and reads
    repeat (10) begin
      case ($urandom_range(9))
        0, 1, 2, 3: send(KIND_DEL, live.size() > 0 ?
                         live[$urandom_range(live.size() - 1)] : rand_addr(), '0);
        4: send(KIND_DEL, rand_addr(), '0);
        5, 6: send(KIND_ADD, rand_addr(), '0);
        7: send(KIND_NOP, rand_addr(), SLOT_W'($urandom_range(1023)));
        default: read_some(2);
      endcase
    end
    read_some(2);

    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
